FILE: src/assert_macros.svh
// Assertion macros shared by the RTL files.
// Simulation builds get concurrent assertions; SYNTH builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

FILE: src/lfu_pkg.sv
// Shared types and constants for the LFU byte-budget cache policy.
// No dependencies.
`default_nettype none
package lfu_pkg;
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int COUNT_W = 16;
    localparam int ADDR_W = 63;
    localparam int LEN_W = 21;
    localparam int READS_W = 16;
    localparam int BYTES_W = 32;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [BYTES_W-1:0] BUDGET_RESET = 32'd16777216;

    localparam logic [1:0] KIND_HIT = 2'd0;
    localparam logic [1:0] KIND_MISS = 2'd1;
    localparam logic [1:0] KIND_EVICT = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] block_addr;
        logic [LEN_W-1:0] block_len;
    } t_req;

    typedef struct packed {
        logic [1:0] kind;
        logic [ADDR_W-1:0] entry_addr;
        logic [LEN_W-1:0] entry_len;
        logic [READS_W-1:0] entry_reads;
        logic last;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, start scan
        logic scan;     // compare slot r_idx, advance
        logic evict;    // drop tail entry, build eviction result
        logic place;    // place entry (hit or miss), build access result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic hit;
        logic need_evict;
    } t_sts;
endpackage
`default_nettype wire

FILE: src/lfu_if.sv
// Valid/ready channels carrying one request or one result word.
// Depends on lfu_pkg for the payload types.
`default_nettype none
interface lfu_req_if;
    logic valid;
    logic ready;
    lfu_pkg::t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
    logic valid;
    logic ready;
    lfu_pkg::t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/lfu_dp.sv
// Datapath: slot table in flip-flops, scan, shift-insert and result builder.
// Depends on lfu_pkg.
`default_nettype none
module lfu_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire lfu_pkg::t_cmd          i_cmd,
    input  wire lfu_pkg::t_req          i_req,
    input  wire logic [lfu_pkg::BYTES_W-1:0] i_budget,
    output lfu_pkg::t_sts               o_sts,
    output lfu_pkg::t_rsp               o_rsp
);
    localparam int D = lfu_pkg::DEPTH;

    logic [lfu_pkg::ADDR_W-1:0]  r_addr [D];
    logic [lfu_pkg::LEN_W-1:0]   r_len  [D];
    logic [lfu_pkg::COUNT_W-1:0] r_cnt  [D];
    logic [lfu_pkg::OCC_W-1:0]   r_occ;
    logic [lfu_pkg::BYTES_W-1:0] r_total;
    lfu_pkg::t_req               r_req;
    logic [lfu_pkg::OCC_W-1:0]   r_idx;
    logic                        r_hit;
    logic [lfu_pkg::IDX_W-1:0]   r_hidx;
    lfu_pkg::t_rsp               r_rsp;

    logic [lfu_pkg::IDX_W-1:0]   w_idx;
    logic [lfu_pkg::IDX_W-1:0]   w_tail;
    logic [lfu_pkg::IDX_W-1:0]   w_pos;
    logic [lfu_pkg::IDX_W-1:0]   w_end;
    logic [lfu_pkg::COUNT_W-1:0] w_cnt;
    logic                        w_found;
    logic                        w_match;

    assign w_idx  = r_idx[lfu_pkg::IDX_W-1:0];
    // last valid slot
    assign w_tail = r_occ[lfu_pkg::IDX_W-1:0] - 1'b1;
    assign w_match = (r_addr[w_idx] == r_req.block_addr) && (r_len[w_idx] == r_req.block_len);

    // new count and insert position: first slot below w_end with count < w_cnt
    // (hit) or == 1 (miss)
    always_comb begin
        w_cnt = r_hit ? ((r_cnt[r_hidx] == lfu_pkg::COUNT_MAX) ? r_cnt[r_hidx]
                                                               : r_cnt[r_hidx] + 1'b1)
                      : lfu_pkg::COUNT_W'(1);
        w_end = r_hit ? r_hidx : r_occ[lfu_pkg::IDX_W-1:0];
        w_pos = w_end;
        w_found = 1'b0;
        for (int i = 0; i < D; i++) begin
            if (!w_found && (lfu_pkg::IDX_W'(i) < w_end) &&
                (r_hit ? (r_cnt[i] < w_cnt) : (r_cnt[i] == lfu_pkg::COUNT_W'(1)))) begin
                w_pos = lfu_pkg::IDX_W'(i);
                w_found = 1'b1;
            end
        end
    end

    assign o_sts.scan_done  = (r_idx == r_occ) || r_hit;
    assign o_sts.hit        = r_hit;
    assign o_sts.need_evict = (r_occ != '0) &&
        ((r_total > i_budget) || (r_occ == lfu_pkg::OCC_W'(D)));
    assign o_rsp = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_total <= '0;
            r_hit   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_req   <= i_req;
                r_idx   <= '0;
                r_hit   <= 1'b0;
                // length counted up front; a hit takes it back at placement
                r_total <= r_total + lfu_pkg::BYTES_W'(i_req.block_len);
            end
            if (i_cmd.scan) begin
                if (w_match) begin
                    r_hit  <= 1'b1;
                    r_hidx <= w_idx;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.evict) begin
                r_occ   <= r_occ - 1'b1;
                r_idx   <= r_occ - 1'b1;
                r_total <= r_total - lfu_pkg::BYTES_W'(r_len[w_tail]);
                r_rsp   <= '{kind: lfu_pkg::KIND_EVICT,
                             entry_addr: r_addr[w_tail],
                             entry_len: r_len[w_tail],
                             entry_reads: r_cnt[w_tail][lfu_pkg::READS_W-1:0],
                             last: 1'b0};
            end
            if (i_cmd.place) begin
                for (int i = 1; i < D; i++) begin
                    if ((lfu_pkg::IDX_W'(i) > w_pos) && (lfu_pkg::IDX_W'(i) <= w_end)) begin
                        r_addr[i] <= r_addr[i-1];
                        r_len[i]  <= r_len[i-1];
                        r_cnt[i]  <= r_cnt[i-1];
                    end
                end
                r_addr[w_pos] <= r_req.block_addr;
                r_len[w_pos]  <= r_req.block_len;
                r_cnt[w_pos]  <= w_cnt;
                if (!r_hit)
                    r_occ <= r_occ + 1'b1;
                else
                    r_total <= r_total - lfu_pkg::BYTES_W'(r_req.block_len);
                r_rsp <= '{kind: r_hit ? lfu_pkg::KIND_HIT : lfu_pkg::KIND_MISS,
                           entry_addr: r_req.block_addr, entry_len: r_req.block_len,
                           entry_reads: w_cnt[lfu_pkg::READS_W-1:0], last: 1'b1};
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= lfu_pkg::OCC_W'(D))
    `ASSERT_NEXT(a_evict_dec, i_clk, i_rst_n, i_cmd.evict, r_occ == $past(r_occ) - 1'b1)
    `ASSERT_IMPLIES(a_scan_range, i_clk, i_rst_n, i_cmd.scan, r_idx < r_occ)
endmodule
`default_nettype wire

FILE: src/lfu_ctrl.sv
// Controller: sequences scan, evictions and placement, drives the handshakes.
// Depends on lfu_pkg.
`default_nettype none
module lfu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire lfu_pkg::t_sts i_sts,
    output lfu_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SEND  = 3'd3;
    localparam logic [2:0] S_SENDL = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_SEND) || (r_state == S_SENDL);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_DEC: begin
                if (!i_sts.hit && i_sts.need_evict) begin
                    o_cmd.evict = 1'b1;
                    n_state = S_SEND;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state = S_SENDL;
                end
            end
            S_SEND:  if (i_out_ready) n_state = S_DEC;
            S_SENDL: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    `include "assert_macros.svh"
    `ASSERT_IMPLIES(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd))
    `ASSERT_NEXT(a_load_scan, i_clk, i_rst_n, o_cmd.load, r_state == S_SCAN)
    `ASSERT_NEXT(a_place_last, i_clk, i_rst_n, o_cmd.place, o_out_valid)
endmodule
`default_nettype wire

FILE: src/lfu_size_budget_cache_policy.sv
// Top level of the LFU byte-budget cache policy.
// Depends on lfu_pkg, lfu_if, lfu_ctrl, lfu_dp.
//
//  channel   dir  payload
//  i_req     in   block_addr[63], block_len[21]
//  o_rsp     out  kind, entry_addr, entry_len, entry_reads, last
//  cfg       in   i_cfg_we, i_cfg_wdata (byte_budget)
//
// One request at a time: load, a scan step for each slot scanned (up to occupancy),
// a scan-end check, a decide and a send per eviction, then placement and its send.
// Scan length is set by the one shared compare over the slot table.
// Synchronous active-low reset empties the table and sets budget to 16 MiB.
// Output stalls hold the result register; input is not taken until done.
`default_nettype none
module lfu_size_budget_cache_policy (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    input  wire logic i_cfg_we,
    input  wire logic [lfu_pkg::BYTES_W-1:0] i_cfg_wdata
);
    logic [lfu_pkg::BYTES_W-1:0] r_budget;
    lfu_pkg::t_cmd w_cmd;
    lfu_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_budget <= lfu_pkg::BUDGET_RESET;
        else if (i_cfg_we) r_budget <= i_cfg_wdata;
    end

    lfu_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    lfu_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_req(i_req.data),
        .i_budget(r_budget), .o_sts(w_sts), .o_rsp(o_rsp.data)
    );
endmodule
`default_nettype wire

FILE: sim/lfu_tb_if.sv
// Scoreboard package: table model of the cache policy and expected results.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
package lfu_tb_pkg;

    typedef struct {
        logic [lfu_pkg::ADDR_W-1:0]  addr;
        logic [lfu_pkg::LEN_W-1:0]   len;
        logic [lfu_pkg::COUNT_W-1:0] reads;
    } t_slot;

    // Models the policy table and queues expected results.
    class lfu_scoreboard;
        t_slot table_q[$];
        logic [lfu_pkg::BYTES_W-1:0] total;
        logic [lfu_pkg::BYTES_W-1:0] budget;
        lfu_pkg::t_rsp pending[$];
        int unsigned mismatches;

        function void clear();
            table_q.delete();
            total = '0;
            budget = lfu_pkg::BUDGET_RESET;
            pending.delete();
            mismatches = 0;
        endfunction

        function lfu_pkg::t_rsp make_rsp(logic [1:0] k, t_slot s, logic lst);
            lfu_pkg::t_rsp r;
            r.kind = k;
            r.entry_addr = s.addr;
            r.entry_len = s.len;
            r.entry_reads = s.reads[lfu_pkg::READS_W-1:0];
            r.last = lst;
            return r;
        endfunction

        // Note an accepted request: update the table, queue its results.
        function void note_request(lfu_pkg::t_req q);
            int h;
            int p;
            t_slot s;
            h = -1;
            foreach (table_q[i])
                if (h < 0 && table_q[i].addr == q.block_addr && table_q[i].len == q.block_len)
                    h = i;
            if (h >= 0) begin
                s = table_q[h];
                if (s.reads != lfu_pkg::COUNT_MAX) s.reads++;
                p = h;
                for (int i = 0; i < h; i++)
                    if (table_q[i].reads < s.reads) begin
                        p = i;
                        break;
                    end
                table_q.delete(h);
                table_q.insert(p, s);
                pending.push_back(make_rsp(lfu_pkg::KIND_HIT, s, 1'b1));
                return;
            end
            total = total + lfu_pkg::BYTES_W'(q.block_len);
            while (table_q.size() > 0 &&
                   (total > budget || table_q.size() >= lfu_pkg::DEPTH)) begin
                s = table_q[table_q.size() - 1];
                table_q.delete(table_q.size() - 1);
                total = total - lfu_pkg::BYTES_W'(s.len);
                pending.push_back(make_rsp(lfu_pkg::KIND_EVICT, s, 1'b0));
            end
            p = table_q.size();
            foreach (table_q[i])
                if (p == table_q.size() && table_q[i].reads == 1) p = i;
            s.addr = q.block_addr;
            s.len = q.block_len;
            s.reads = 1;
            table_q.insert(p, s);
            pending.push_back(make_rsp(lfu_pkg::KIND_MISS, s, 1'b1));
        endfunction

        function void check_result(lfu_pkg::t_rsp got);
            lfu_pkg::t_rsp want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass
endpackage

FILE: sim/lfu_size_budget_cache_policy_tb.sv
// Testbench for lfu_size_budget_cache_policy: directed and random requests, idling on
// both channels, checked against a scoreboard model. Depends on lfu_pkg, lfu_if.
`timescale 1ns / 1ps
module lfu_size_budget_cache_policy_tb;

    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lfu_pkg::BYTES_W-1:0] i_cfg_wdata = '0;
    int unsigned cycles = 0;

    lfu_req_if req_ch ();
    lfu_rsp_if rsp_ch ();

    lfu_tb_pkg::lfu_scoreboard lfu_model = new();
    // working set of addresses so hits are common
    logic [lfu_pkg::ADDR_W-1:0] hot_addr[8];
    logic [lfu_pkg::LEN_W-1:0]  hot_len[8];

    lfu_size_budget_cache_policy dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("lfu_size_budget_cache_policy_tb: errors");
            $finish;
        end
    end

    // result sink: random stall per result, check on each handshake
    initial begin : result_sink
        int stall;
        lfu_model.clear();
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk iff rsp_ch.valid);
            lfu_model.check_result(rsp_ch.data);
        end
    end

    // valid stays up after a handshake until the next request or an idle gap
    task automatic send_request(logic [lfu_pkg::ADDR_W-1:0] a,
                                logic [lfu_pkg::LEN_W-1:0] l, bit calm);
        int gap;
        lfu_pkg::t_req q;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        q.block_addr = a;
        q.block_len = l;
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        @(posedge i_clk iff req_ch.ready);
        lfu_model.note_request(q);
    endtask

    // drop valid, wait for the scoreboard to drain, plus settle time
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (lfu_model.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_budget(logic [lfu_pkg::BYTES_W-1:0] b);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lfu_model.budget = b;
    endtask

    task automatic random_phase(int n, int len_max);
        int k;
        logic [lfu_pkg::ADDR_W-1:0] a;
        logic [lfu_pkg::LEN_W-1:0] l;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            if (k < 7) begin
                a = hot_addr[k];
                l = hot_len[k];
            end else begin
                a = lfu_pkg::ADDR_W'({$urandom(), $urandom()});
                l = lfu_pkg::LEN_W'($urandom_range(0, len_max));
                if (k == 9) l = lfu_pkg::LEN_W'($urandom()); // any width value, all bits
            end
            send_request(a, l, (i % 40) < 6);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (hot_addr[i]) begin
            hot_addr[i] = lfu_pkg::ADDR_W'({$urandom(), $urandom()});
            hot_len[i] = lfu_pkg::LEN_W'($urandom_range(1, 4096));
        end
        hot_addr[0] = '1;
        hot_addr[1] = '0;
        hot_len[2] = '1;
        hot_len[3] = 21'd1048576;

        // directed: extremes, zero length, repeat hits, full table
        send_request('0, 21'd0, 1'b0);
        send_request('1, '1, 1'b0);
        send_request('1, '1, 1'b0);
        send_request('0, 21'd0, 1'b0);
        send_request('0, 21'd0, 1'b0);
        for (int i = 0; i < 17; i++)
            send_request(lfu_pkg::ADDR_W'(i + 100), 21'd16, 1'b0);
        // pause until every result has come
        drain();
        // oversized block flushes table
        set_budget(32'd1000);
        send_request(lfu_pkg::ADDR_W'(7), 21'd2000, 1'b0);
        send_request(lfu_pkg::ADDR_W'(7), 21'd2000, 1'b0);

        set_budget(32'd0);
        random_phase(25, 64);
        set_budget(32'd20000);
        random_phase(60, 4096);
        set_budget(32'hFFFF_FFFF);
        random_phase(60, 1048576);
        set_budget(lfu_pkg::BUDGET_RESET);
        random_phase(41, 1048576);

        drain();
        if (lfu_model.mismatches == 0 && lfu_model.pending.size() == 0)
            $display("lfu_size_budget_cache_policy_tb: clean");
        else
            $display("lfu_size_budget_cache_policy_tb: errors");
        $finish;
    end
endmodule
